### design/bah_pkg.sv
// ----------------------------------------------------------------------------
// bah_pkg: shared definitions for the block average hold core
// Register map, field widths, reset values, sequencer states and the
// status bundle of the shared divider.
// ----------------------------------------------------------------------------
`default_nettype none

package bah_pkg;

  localparam int BLEN_W          = 7;
  localparam int SEQ_W           = 16;
  localparam int VALUE_W         = 16;
  localparam int CFG_DATA_W      = 32;
  localparam int CFG_ADDR_W      = 3;
  localparam int MAX_BLOCK_DEF   = 64;
  localparam int SAMPLE_BITS_DEF = 16;

  localparam logic [BLEN_W-1:0] BLEN_RST = 7'd2;
  localparam logic [SEQ_W-1:0]  SEQ_RST  = 16'd1024;

  typedef enum logic [0:0] {
    REG_BLOCK_LEN = 1'b0,
    REG_SEQ_LEN   = 1'b1
  } reg_idx_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_BURST
  } state_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

`default_nettype wire

### design/bah_div.sv
// ----------------------------------------------------------------------------
// bah_div: restoring divider, one quotient bit per cycle
// Takes a start pulse with dividend and divisor, runs one step per quotient
// bit and pulses done with the quotient held until the next start.
// ----------------------------------------------------------------------------
`default_nettype none

module bah_div
  import bah_pkg::*;
#(
  parameter int NW = 24,
  parameter int DW = 8
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          start,
  input  wire logic [NW-1:0] dividend,
  input  wire logic [DW-1:0] divisor,
  output div_stat_t          stat,
  output logic      [NW-1:0] quotient
);

  localparam int CW = (NW > 1) ? $clog2(NW) : 1;

  logic [NW-1:0] quo_r;
  logic [DW-1:0] rem_r;
  logic [DW-1:0] dvs_r;
  logic [CW-1:0] cnt_r;
  logic          busy_r;
  logic          done_r;

  logic [DW:0]   shifted;
  logic [DW+1:0] trial;
  logic          borrow;

  assign shifted = {rem_r, quo_r[NW-1]};
  assign trial   = {1'b0, shifted} - {2'b00, dvs_r};
  assign borrow  = trial[DW+1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CW'(NW - 1);
      end else if (busy_r) begin
        if (cnt_r == '0) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end else begin
          cnt_r <= cnt_r - CW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo_r <= dividend;
      rem_r <= '0;
      dvs_r <= divisor;
    end else if (busy_r) begin
      quo_r <= {quo_r[NW-2:0], ~borrow};
      rem_r <= borrow ? shifted[DW-1:0] : trial[DW-1:0];
    end
  end

  assign stat.busy = busy_r;
  assign stat.done = done_r;
  assign quotient  = quo_r;

endmodule

`default_nettype wire

### design/block_average_hold_core.sv
// ----------------------------------------------------------------------------
// block_average_hold_core: block mean, sample and hold
// Splits each sequence into blocks, emits the rounded block mean once per
// sample of a full block; tail samples, and all while disabled, pass raw.
// ----------------------------------------------------------------------------
// A sample that passes through raw, or that only adds to the running block
// sum, is taken at once, so such samples stream at one per cycle while the
// output side keeps up. The sample that completes a block starts the
// restoring divider; the input is not ready while the divider runs and
// hands over its quotient, nor while the held mean goes out as block_len
// results. Raw results carry tuser = 0, means carry tuser = 1, and tlast
// marks the final result caused by one sample.
`default_nettype none

module block_average_hold_core
  import bah_pkg::*;
#(
  parameter int MAX_BLOCK   = MAX_BLOCK_DEF,
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst_n,
  input  wire logic                                 in_tvalid,
  output logic                                      in_tready,
  input  wire logic [((SAMPLE_BITS+7)/8)*8-1:0]     in_tdata,   // sample
  output logic                                      out_tvalid,
  input  wire logic                                 out_tready,
  output logic      [VALUE_W-1:0]                   out_tdata,  // value
  output logic      [0:0]                           out_tuser,  // averaged
  output logic                                      out_tlast,
  input  wire logic                                 cfg_psel,
  input  wire logic                                 cfg_penable,
  input  wire logic                                 cfg_pwrite,
  input  wire logic [CFG_ADDR_W-1:0]                cfg_paddr,
  input  wire logic [CFG_DATA_W-1:0]                cfg_pwdata,
  output logic      [CFG_DATA_W-1:0]                cfg_prdata,
  output logic                                      cfg_pready
);

  localparam int SUM_W = SAMPLE_BITS + $clog2(MAX_BLOCK) + 1;
  localparam int NW    = SUM_W + 1;
  localparam int DW    = BLEN_W + 1;
  localparam int LEN_W = SEQ_W + 1;

  logic [BLEN_W-1:0]  blen_r;
  logic [SEQ_W-1:0]   slen_r;
  logic [SUM_W-1:0]   sum_r, sum_nxt;
  logic [BLEN_W-1:0]  pos_r, pos_nxt;
  logic [SEQ_W-1:0]   idx_r, idx_nxt;
  state_t             state_r, state_nxt;
  logic               neg_r;
  logic [VALUE_W-1:0] mean_r;
  logic [BLEN_W-1:0]  bcnt_r;
  logic               out_valid_r;
  logic [VALUE_W-1:0] out_value_r;
  logic               out_avg_r;
  logic               out_last_r;

  logic                   cfg_wr;
  reg_idx_t               cfg_idx;
  logic [LEN_W-1:0]       len;
  logic                   enabled;
  logic                   in_avg;
  logic                   blk_done;
  logic                   out_free;
  logic                   in_acc;
  logic                   raw_load;
  logic                   burst_load;
  logic                   burst_last;
  logic                   div_start;
  logic [SAMPLE_BITS-1:0] sample;
  logic [SUM_W-1:0]       x_ext;
  logic [SUM_W-1:0]       sum_add;
  logic [SUM_W-1:0]       mag;
  logic [NW-1:0]          dividend;
  logic [DW-1:0]          divisor;
  logic [NW-1:0]          quotient;
  logic [NW-1:0]          mean_full;
  logic [SAMPLE_BITS-1:0] mean_sb;
  logic [LEN_W-1:0]       idx_inc;
  div_stat_t              div_stat;

  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign cfg_idx    = reg_idx_t'(cfg_paddr[2]);
  assign cfg_pready = 1'b1;

  always_comb begin
    case (cfg_idx)
      REG_BLOCK_LEN: cfg_prdata = CFG_DATA_W'(blen_r);
      REG_SEQ_LEN:   cfg_prdata = CFG_DATA_W'(slen_r);
      default:       cfg_prdata = '0;
    endcase
  end

  assign len      = (slen_r == '0) ? {1'b1, {SEQ_W{1'b0}}} : {1'b0, slen_r};
  assign enabled  = (blen_r != '0) && (LEN_W'({blen_r, 1'b0}) <= len)
                    && (int'(blen_r) <= MAX_BLOCK);
  assign in_avg   = enabled
                    && ((pos_r != '0) || ({1'b0, idx_r} + LEN_W'(blen_r) <= len));
  assign blk_done = in_avg && (BLEN_W'(pos_r + BLEN_W'(1)) == blen_r);
  assign out_free = !out_valid_r || out_tready;

  assign sample  = in_tdata[SAMPLE_BITS-1:0];
  assign x_ext   = {{(SUM_W-SAMPLE_BITS){sample[SAMPLE_BITS-1]}}, sample};
  assign sum_add = sum_r + x_ext;
  assign mag     = sum_add[SUM_W-1] ? (~sum_add + SUM_W'(1)) : sum_add;
  assign dividend = {mag, 1'b0} + NW'(blen_r);
  assign divisor  = {blen_r, 1'b0};

  assign burst_last = (bcnt_r == BLEN_W'(blen_r - BLEN_W'(1)));

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE:  if (in_acc && blk_done) state_nxt = ST_DIV;
      ST_DIV:   if (div_stat.done) state_nxt = ST_BURST;
      ST_BURST: if (out_free && burst_last) state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    in_tready  = 1'b0;
    burst_load = 1'b0;
    case (state_r)
      ST_IDLE:  in_tready  = in_avg || out_free;
      ST_DIV:   in_tready  = 1'b0;
      ST_BURST: burst_load = out_free;
      default:  in_tready  = 1'b0;
    endcase
  end

  assign in_acc    = in_tvalid && in_tready;
  assign raw_load  = in_acc && !in_avg;
  assign div_start = in_acc && blk_done;

  bah_div #(
    .NW(NW),
    .DW(DW)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (dividend),
    .divisor  (divisor),
    .stat     (div_stat),
    .quotient (quotient)
  );

  assign mean_full = neg_r ? (~quotient + NW'(1)) : quotient;
  assign mean_sb   = mean_full[SAMPLE_BITS-1:0];
  assign idx_inc   = {1'b0, idx_r} + LEN_W'(1);

  always_comb begin
    sum_nxt = sum_r;
    pos_nxt = pos_r;
    idx_nxt = idx_r;
    if (cfg_wr) begin
      sum_nxt = '0;
      pos_nxt = '0;
      idx_nxt = '0;
    end else if (in_acc) begin
      if (in_avg) begin
        if (blk_done) begin
          sum_nxt = '0;
          pos_nxt = '0;
        end else begin
          sum_nxt = sum_add;
          pos_nxt = pos_r + BLEN_W'(1);
        end
      end
      if (idx_inc >= len) begin
        sum_nxt = '0;
        pos_nxt = '0;
        idx_nxt = '0;
      end else begin
        idx_nxt = idx_inc[SEQ_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      blen_r      <= BLEN_RST;
      slen_r      <= SEQ_RST;
      sum_r       <= '0;
      pos_r       <= '0;
      idx_r       <= '0;
      state_r     <= ST_IDLE;
      bcnt_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_wr) begin
        case (cfg_idx)
          REG_BLOCK_LEN: blen_r <= cfg_pwdata[BLEN_W-1:0];
          REG_SEQ_LEN:   slen_r <= cfg_pwdata[SEQ_W-1:0];
          default:       blen_r <= blen_r;
        endcase
      end
      sum_r   <= sum_nxt;
      pos_r   <= pos_nxt;
      idx_r   <= idx_nxt;
      state_r <= state_nxt;
      if (div_stat.done) begin
        bcnt_r <= '0;
      end else if (burst_load) begin
        bcnt_r <= bcnt_r + BLEN_W'(1);
      end
      if (raw_load || burst_load) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (div_start) begin
      neg_r <= sum_add[SUM_W-1];
    end
    if (div_stat.done) begin
      mean_r <= VALUE_W'(mean_sb);
    end
    if (raw_load) begin
      out_value_r <= VALUE_W'(sample);
      out_avg_r   <= 1'b0;
      out_last_r  <= 1'b1;
    end else if (burst_load) begin
      out_value_r <= mean_r;
      out_avg_r   <= 1'b1;
      out_last_r  <= burst_last;
    end
  end

  assign out_tvalid   = out_valid_r;
  assign out_tdata    = out_value_r;
  assign out_tuser[0] = out_avg_r;
  assign out_tlast    = out_last_r;

endmodule

`default_nettype wire

### design/bah_check.sv
// ----------------------------------------------------------------------------
// bah_check: port-level checks for the block average hold core
// Watches the top-level ports over time and is bound to the core.
// ----------------------------------------------------------------------------
`default_nettype none

module bah_check
  import bah_pkg::*;
#(
  parameter int MAX_BLOCK   = MAX_BLOCK_DEF,
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input wire logic                             clk,
  input wire logic                             rst_n,
  input wire logic                             in_tvalid,
  input wire logic                             in_tready,
  input wire logic [((SAMPLE_BITS+7)/8)*8-1:0] in_tdata,
  input wire logic                             out_tvalid,
  input wire logic                             out_tready,
  input wire logic [VALUE_W-1:0]               out_tdata,
  input wire logic [0:0]                       out_tuser,
  input wire logic                             out_tlast,
  input wire logic                             cfg_psel,
  input wire logic                             cfg_penable,
  input wire logic                             cfg_pwrite,
  input wire logic [CFG_ADDR_W-1:0]            cfg_paddr,
  input wire logic [CFG_DATA_W-1:0]            cfg_pwdata,
  input wire logic [CFG_DATA_W-1:0]            cfg_prdata,
  input wire logic                             cfg_pready
);

  logic cfg_wr;
  assign cfg_wr = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  a_reset_clears_out: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

  a_raw_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser[0] |-> out_tlast)
    else $error("raw result without last flag");

  a_pready_high: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_pready)
    else $error("config port stalled");

  a_blen_readback: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_wr && !cfg_paddr[2] |=>
      cfg_paddr[2] || (cfg_prdata == CFG_DATA_W'($past(cfg_pwdata[BLEN_W-1:0]))))
    else $error("block length readback mismatch");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("stalled result changed");

endmodule

bind block_average_hold_core bah_check #(
  .MAX_BLOCK   (MAX_BLOCK),
  .SAMPLE_BITS (SAMPLE_BITS)
) u_bah_check (.*);

`default_nettype wire

### sim/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top: testbench for the block average hold core
// Drives signed samples into the core, predicts the held block means and
// the raw pass-through results, and checks every result item in order.
// Registers are rewritten between phases: a directed set of corner cases
// comes first, then random phases with random gaps on both streams and one
// long receiver hold-off that backs the core up.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_top;
  import bah_pkg::*;

  typedef struct packed {
    logic [VALUE_W-1:0] value;
    logic               averaged;
    logic               run_last;
  } mean_item_t;

  class mean_tracker;
    int         block_len;
    int         seq_len;
    longint     block_sum;
    int         block_pos;
    int         seq_index;
    mean_item_t due_results[$];
    int         errors;
    int         samples;
    int         means_seen;
    int         raws_seen;

    function new();
      block_len = int'(BLEN_RST);
      seq_len   = int'(SEQ_RST);
      restart();
    endfunction

    function void restart();
      block_sum = 0;
      block_pos = 0;
      seq_index = 0;
    endfunction

    function void queue_result(mean_item_t it);
      due_results = {due_results, it};
    endfunction

    function void set_reg(reg_idx_t idx, logic [CFG_DATA_W-1:0] d);
      if (idx == REG_BLOCK_LEN) begin
        block_len = int'(d[BLEN_W-1:0]);
      end else begin
        seq_len = int'(d[SEQ_W-1:0]);
      end
      restart();
    endfunction

    function void note_sample(logic [VALUE_W-1:0] x);
      int                 span;
      bit                 on;
      longint             mag;
      longint             q;
      logic [VALUE_W-1:0] m;
      span = (seq_len == 0) ? 65536 : seq_len;
      on = (block_len != 0) && (block_len <= span / 2) && (block_len <= MAX_BLOCK_DEF);
      samples++;
      if (on && seq_index < (span / block_len) * block_len) begin
        block_sum += longint'($signed(x));
        block_pos++;
        if (block_pos >= block_len) begin
          mag = (block_sum < 0) ? -block_sum : block_sum;
          q = (2 * mag + block_len) / (2 * block_len);
          m = (block_sum < 0) ? VALUE_W'(-q) : VALUE_W'(q);
          for (int k = 0; k < block_len; k++) begin
            queue_result('{value: m, averaged: 1'b1,
                           run_last: (k == block_len - 1)});
          end
          block_sum = 0;
          block_pos = 0;
        end
      end else begin
        queue_result('{value: x, averaged: 1'b0, run_last: 1'b1});
      end
      seq_index++;
      if (seq_index >= span) restart();
    endfunction

    function void check_result(logic [VALUE_W-1:0] v, logic avg, logic last);
      mean_item_t want;
      if (due_results.size() == 0) begin
        $error("unexpected result item: value %0d averaged %0b last %0b",
               $signed(v), avg, last);
        errors++;
        return;
      end
      want = due_results.pop_front();
      if (avg) means_seen++;
      else raws_seen++;
      if (v !== want.value) begin
        $error("value: expected %0d, actual %0d", $signed(want.value), $signed(v));
        errors++;
      end
      if (avg !== want.averaged) begin
        $error("averaged: expected %0b, actual %0b", want.averaged, avg);
        errors++;
      end
      if (last !== want.run_last) begin
        $error("run_last: expected %0b, actual %0b", want.run_last, last);
        errors++;
      end
    endfunction
  endclass

  localparam int SETTLE_CYCLES = 40;
  localparam int HOLD_CYCLES   = 300;
  localparam int RAND_ITEMS    = 72;

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  in_tvalid;
  logic                  in_tready;
  logic [VALUE_W-1:0]    in_tdata;
  logic                  out_tvalid;
  logic                  out_tready;
  logic [VALUE_W-1:0]    out_tdata;
  logic [0:0]            out_tuser;
  logic                  out_tlast;
  logic                  cfg_psel;
  logic                  cfg_penable;
  logic                  cfg_pwrite;
  logic [CFG_ADDR_W-1:0] cfg_paddr;
  logic [CFG_DATA_W-1:0] cfg_pwdata;
  logic [CFG_DATA_W-1:0] cfg_prdata;
  logic                  cfg_pready;

  logic quiet;
  logic pressure_go;
  int   settings;

  mean_tracker sb = new();

  block_average_hold_core uut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),     // sample
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),    // value
    .out_tuser   (out_tuser),    // averaged
    .out_tlast   (out_tlast),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  always #5 clk = ~clk;

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (quiet || r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [VALUE_W-1:0] pick_sample();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return 16'h7FFF;
    if (r == 1) return 16'h8000;
    return VALUE_W'($urandom);
  endfunction

  task automatic put_sample(input logic [VALUE_W-1:0] x);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= x;
    do @(posedge clk); while (!in_tready);
    sb.note_sample(x);
  endtask

  // drop valid, wait for every due result, then let the divider settle
  task automatic drain();
    in_tvalid <= 1'b0;
    while (sb.due_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input reg_idx_t idx, input logic [CFG_DATA_W-1:0] d);
    drain();
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= {idx, 2'b00};
    cfg_pwdata  <= d;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    sb.set_reg(idx, d);
  endtask

  task automatic set_both(input int bl, input int sl, input bit noisy);
    logic [CFG_DATA_W-1:0] d;
    d = noisy ? CFG_DATA_W'($urandom) : '0;
    d[BLEN_W-1:0] = BLEN_W'(bl);
    write_reg(REG_BLOCK_LEN, d);
    d = noisy ? CFG_DATA_W'($urandom) : '0;
    d[SEQ_W-1:0] = SEQ_W'(sl);
    write_reg(REG_SEQ_LEN, d);
    settings++;
  endtask

  // result side: check, then pick the next ready level
  initial begin : receiver
    int  stall_left;
    bit  held;
    stall_left = 0;
    held = 1'b0;
    out_tready <= 1'b0;
    forever begin
      @(posedge clk);
      if (out_tvalid && out_tready) sb.check_result(out_tdata, out_tuser[0], out_tlast);
      if (pressure_go && !held) begin
        held = 1'b1;
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else if (stall_left > 0) begin
        stall_left--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
        if ($urandom_range(0, 3) == 0) stall_left = pick_gap();
      end
    end
  end

  initial begin : timeout
    #20_000_000;
    $display("Verification failed");
    $finish;
  end

  initial begin : main
    int rand_items;
    int n;
    int bl;
    int sl;
    int r;
    rand_items  = 0;
    settings    = 1;
    quiet       <= 1'b0;
    pressure_go <= 1'b0;
    rst_n       <= 1'b0;
    in_tvalid   <= 1'b0;
    in_tdata    <= '0;
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    cfg_paddr   <= '0;
    cfg_pwdata  <= '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset settings: pairs at the extremes and rounding ties
    put_sample(16'h7FFF); put_sample(16'h7FFF);
    put_sample(16'h8000); put_sample(16'h8000);
    put_sample(16'h0001); put_sample(16'h0002);
    put_sample(16'hFFFF); put_sample(16'hFFFE);
    put_sample(16'h7FFF); put_sample(16'h8000);
    // averaging off
    write_reg(REG_BLOCK_LEN, 32'd0);
    settings++;
    put_sample(16'h8000); put_sample(16'h7FFF);
    // two full blocks, one tail sample, then wrap with a block left open
    set_both(3, 7, 1'b0);
    put_sample(16'h0001); put_sample(16'h0002); put_sample(16'h0004);
    put_sample(16'hFFFF); put_sample(16'hFFFF); put_sample(16'hFFFE);
    put_sample(16'h0005); put_sample(16'h0003);
    // block longer than half the sequence
    set_both(3, 5, 1'b0);
    put_sample(16'h1234);
    // block longer than the largest supported block
    set_both(127, 1024, 1'b0);
    put_sample(16'hABCD);
    // single-sample blocks over the longest sequence
    set_both(1, 0, 1'b0);
    put_sample(16'h8000); put_sample(16'h7FFF);

    // random phases; the first one uses the largest block under pressure
    while (rand_items < RAND_ITEMS) begin
      if (rand_items == 0) begin
        bl = MAX_BLOCK_DEF;
        sl = 2 * MAX_BLOCK_DEF;
        n  = MAX_BLOCK_DEF + 4;
      end else begin
        r = $urandom_range(0, 9);
        if (r == 0) bl = 0;
        else if (r == 1) bl = $urandom_range(MAX_BLOCK_DEF + 1, 127);
        else bl = $urandom_range(1, 6);
        r = $urandom_range(0, 9);
        if (r == 0) sl = 0;
        else if (r == 1) sl = 65535;
        else if (r == 2) sl = 1;
        else sl = $urandom_range(2, 4 * (bl % 8) + 8);
        n = $urandom_range(3, 24);
      end
      set_both(bl, sl, 1'b1);
      quiet <= (rand_items == 0) || ($urandom_range(0, 3) == 0);
      if (rand_items == 0) pressure_go <= 1'b1;
      repeat (n) put_sample(pick_sample());
      rand_items += n;
    end

    drain();
    $display("Checked %0d samples over %0d register settings:", sb.samples, settings);
    $display("  %0d held block means and %0d raw pass-through results.",
             sb.means_seen, sb.raws_seen);
    if (sb.errors == 0 && sb.due_results.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

`default_nettype wire

### block_average_hold_core.f
design/bah_pkg.sv
design/bah_div.sv
design/block_average_hold_core.sv
design/bah_check.sv
sim/tb_top.sv
